// ===== hw/rtl/cams_pkg.sv =====
`default_nettype none

package cams_pkg;

    // sequencer phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_OP1      = 3'd1;
    localparam logic [2:0] PH_OP2      = 3'd2;
    localparam logic [2:0] PH_DUMMY_ZP = 3'd3;
    localparam logic [2:0] PH_PTR_LO   = 3'd4;
    localparam logic [2:0] PH_PTR_HI   = 3'd5;
    localparam logic [2:0] PH_FIX      = 3'd6;

    // addressing modes
    localparam logic [3:0] M_IMM = 4'd0;
    localparam logic [3:0] M_ZP  = 4'd1;
    localparam logic [3:0] M_ZPX = 4'd2;
    localparam logic [3:0] M_ZPY = 4'd3;
    localparam logic [3:0] M_ABS = 4'd4;
    localparam logic [3:0] M_ABX = 4'd5;
    localparam logic [3:0] M_ABY = 4'd6;
    localparam logic [3:0] M_REL = 4'd7;
    localparam logic [3:0] M_IND = 4'd8;
    localparam logic [3:0] M_IZX = 4'd9;
    localparam logic [3:0] M_IZY = 4'd10;

    // input actions and result kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  active_mode;
        logic        force_flag;
        logic [15:0] prog_counter;
        logic [7:0]  saved_x;
        logic [7:0]  saved_y;
        logic [7:0]  low_byte;
        logic [15:0] pointer;
    } t_state;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [15:0] bus_address;
        logic        is_dummy;
        logic [15:0] new_pc;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/cams_step.sv =====
`default_nettype none

module cams_step (
    input  var cams_pkg::t_state  i_state,
    input  wire                   i_action,
    input  wire  [3:0]            i_mode,
    input  wire                   i_always_fix,
    input  wire  [15:0]           i_pc,
    input  wire  [7:0]            i_index_x,
    input  wire  [7:0]            i_index_y,
    input  wire  [7:0]            i_read_data,
    output cams_pkg::t_state      o_state,
    output cams_pkg::t_result     o_result
);
    import cams_pkg::*;

    logic [15:0] pc_inc;
    logic [15:0] base;
    logic [7:0]  idx;
    logic [15:0] idx_addr;
    logic        idx_fix;
    logic [15:0] rel_addr;

    // shared address arithmetic
    assign pc_inc   = i_state.prog_counter + 16'd1;
    assign base     = (i_state.phase == PH_OP2) ? {i_read_data, i_state.low_byte}
                                                : {i_read_data, i_state.low_byte};
    assign idx      = (i_state.active_mode == M_ABX) ? i_state.saved_x : i_state.saved_y;
    assign idx_addr = base + {8'd0, idx};
    assign idx_fix  = i_state.force_flag ||
                      ((base & PAGE_MASK) != (idx_addr & PAGE_MASK));
    assign rel_addr = pc_inc + {{8{i_read_data[7]}}, i_read_data};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_action == ACT_START) begin
            // start: latch operands, then either done or fetch first operand byte
            o_state.active_mode  = i_mode;
            o_state.force_flag   = i_always_fix;
            o_state.prog_counter = i_pc;
            o_state.saved_x      = i_index_x;
            o_state.saved_y      = i_index_y;
            o_state.low_byte     = 8'd0;
            o_state.pointer      = 16'd0;
            o_result.valid       = 1'b1;
            o_result.bus_address = i_pc;
            if (i_mode == M_IMM || i_mode > M_IZY) begin
                o_state.phase         = PH_IDLE;
                o_state.prog_counter  = i_pc + 16'd1;
                o_result.kind         = KIND_DONE;
                o_result.new_pc       = i_pc + 16'd1;
            end else begin
                o_state.phase = PH_OP1;
                o_result.kind = KIND_READ;
            end
        end else begin
            o_result.valid = 1'b1;
            case (i_state.phase)
                PH_OP1: begin
                    o_state.prog_counter = pc_inc;
                    o_state.low_byte     = i_read_data;
                    case (i_state.active_mode)
                        M_ZP: begin
                            o_state.phase        = PH_IDLE;
                            o_result.kind        = KIND_DONE;
                            o_result.bus_address = {8'd0, i_read_data};
                            o_result.new_pc      = pc_inc;
                        end
                        M_ZPX, M_IZX: begin
                            o_state.pointer      = {8'd0, i_read_data + i_state.saved_x};
                            o_state.phase        = PH_DUMMY_ZP;
                            o_result.kind        = KIND_READ;
                            o_result.bus_address = {8'd0, i_read_data};
                            o_result.is_dummy    = 1'b1;
                        end
                        M_ZPY: begin
                            o_state.pointer      = {8'd0, i_read_data + i_state.saved_y};
                            o_state.phase        = PH_DUMMY_ZP;
                            o_result.kind        = KIND_READ;
                            o_result.bus_address = {8'd0, i_read_data};
                            o_result.is_dummy    = 1'b1;
                        end
                        M_REL: begin
                            o_state.phase        = PH_IDLE;
                            o_result.kind        = KIND_DONE;
                            o_result.bus_address = rel_addr;
                            o_result.new_pc      = pc_inc;
                        end
                        M_IZY: begin
                            o_state.pointer      = {8'd0, i_read_data};
                            o_state.phase        = PH_PTR_LO;
                            o_result.kind        = KIND_READ;
                            o_result.bus_address = {8'd0, i_read_data};
                        end
                        default: begin
                            // two-byte operand modes fetch the high byte
                            o_state.phase        = PH_OP2;
                            o_result.kind        = KIND_READ;
                            o_result.bus_address = pc_inc;
                        end
                    endcase
                end
                PH_OP2: begin
                    o_state.prog_counter = pc_inc;
                    if (i_state.active_mode == M_ABX || i_state.active_mode == M_ABY) begin
                        if (idx_fix) begin
                            o_state.pointer      = idx_addr;
                            o_state.phase        = PH_FIX;
                            o_result.kind        = KIND_READ;
                            o_result.bus_address = (base & PAGE_MASK) | (idx_addr & BYTE_MASK);
                            o_result.is_dummy    = 1'b1;
                        end else begin
                            o_state.phase        = PH_IDLE;
                            o_result.kind        = KIND_DONE;
                            o_result.bus_address = idx_addr;
                            o_result.new_pc      = pc_inc;
                        end
                    end else if (i_state.active_mode == M_IND) begin
                        o_state.pointer      = base;
                        o_state.phase        = PH_PTR_LO;
                        o_result.kind        = KIND_READ;
                        o_result.bus_address = base;
                    end else begin
                        o_state.phase        = PH_IDLE;
                        o_result.kind        = KIND_DONE;
                        o_result.bus_address = base;
                        o_result.new_pc      = pc_inc;
                    end
                end
                PH_DUMMY_ZP: begin
                    o_result.bus_address = i_state.pointer;
                    if (i_state.active_mode == M_IZX) begin
                        o_state.phase = PH_PTR_LO;
                        o_result.kind = KIND_READ;
                    end else begin
                        o_state.phase   = PH_IDLE;
                        o_result.kind   = KIND_DONE;
                        o_result.new_pc = i_state.prog_counter;
                    end
                end
                PH_PTR_LO: begin
                    // pointer high byte read, wrapping within the page
                    o_state.low_byte = i_read_data;
                    o_state.phase    = PH_PTR_HI;
                    o_result.kind    = KIND_READ;
                    if (i_state.active_mode == M_IND) begin
                        o_result.bus_address = {i_state.pointer[15:8],
                                                i_state.pointer[7:0] + 8'd1};
                    end else begin
                        o_result.bus_address = {8'd0, i_state.pointer[7:0] + 8'd1};
                    end
                end
                PH_PTR_HI: begin
                    if (i_state.active_mode == M_IZY && idx_fix) begin
                        o_state.pointer      = idx_addr;
                        o_state.phase        = PH_FIX;
                        o_result.kind        = KIND_READ;
                        o_result.bus_address = (base & PAGE_MASK) | (idx_addr & BYTE_MASK);
                        o_result.is_dummy    = 1'b1;
                    end else begin
                        o_state.phase        = PH_IDLE;
                        o_result.kind        = KIND_DONE;
                        o_result.bus_address = (i_state.active_mode == M_IZY) ? idx_addr
                                                                              : base;
                        o_result.new_pc      = i_state.prog_counter;
                    end
                end
                PH_FIX: begin
                    o_state.phase        = PH_IDLE;
                    o_result.kind        = KIND_DONE;
                    o_result.bus_address = i_state.pointer;
                    o_result.new_pc      = i_state.prog_counter;
                end
                default: begin
                    // data while idle is dropped
                    o_state.phase  = PH_IDLE;
                    o_result.valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_address_mode_sequencer.sv =====
// 6502 operand address resolution.
// Input channel (i_in_valid / o_in_ready): a start transfer (action 0) carries
// mode, pc, X, Y and i_always_fix; a data transfer (action 1) returns the byte
// for the last bus read that the block requested.
// Output channel (o_out_valid / i_out_ready): each transfer is either a bus
// read request (kind 0, with is_dummy) or a done item (kind 1) carrying the
// effective address and the pc after the operand bytes.
// Every input transfer is worked out combinationally by the step logic and the
// result is in the output register in the cycle after acceptance; a data
// transfer while idle yields no result.
// Throughput is one input transfer per cycle unless the receiver stalls.
// o_in_ready is high while the output register is empty or being taken in
// the same cycle, so a stalled receiver holds the result and back-pressures
// the input after one item. A start while a resolution is in progress
// abandons it and begins anew. Synchronous active-low reset returns the
// sequencer to idle and empties the output register.
`default_nettype none

module cpu_address_mode_sequencer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_action,
    input  wire  [3:0]  i_mode,
    input  wire         i_always_fix,
    input  wire  [15:0] i_pc,
    input  wire  [7:0]  i_index_x,
    input  wire  [7:0]  i_index_y,
    input  wire  [7:0]  i_read_data,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_kind,
    output logic [15:0] o_bus_address,
    output logic        o_is_dummy,
    output logic [15:0] o_new_pc
);
    import cams_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    r_out_valid;
    logic    r_kind;
    logic [15:0] r_bus_address;
    logic    r_is_dummy;
    logic [15:0] r_new_pc;
    logic    in_xfer;

    // next state and result for the offered item
    cams_step u_step (
        .i_state       (r_state),
        .i_action      (i_action),
        .i_mode        (i_mode),
        .i_always_fix  (i_always_fix),
        .i_pc          (i_pc),
        .i_index_x     (i_index_x),
        .i_index_y     (i_index_y),
        .i_read_data   (i_read_data),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= n_result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_result.valid) begin
            r_kind        <= n_result.kind;
            r_bus_address <= n_result.bus_address;
            r_is_dummy    <= n_result.is_dummy;
            r_new_pc      <= n_result.new_pc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_bus_address = r_bus_address;
    assign o_is_dummy    = r_is_dummy;
    assign o_new_pc      = r_new_pc;

endmodule

`default_nettype wire
